@@ rtl/core/nsd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_pkg
// Shared types and codes for the sentence deframer: character codes, keyword
// codes, event and error codes, and the item formats between the parts.
// ----------------------------------------------------------------------------
package nsd_pkg;

  // default payload limit in bytes
  localparam int MAX_PAYLOAD_DEF = 64;

  // item queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // framing characters
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  // keywords, first character in the top byte
  localparam logic [23:0] KW_CHA = 24'h434841;
  localparam logic [23:0] KW_ACC = 24'h414343;
  localparam logic [23:0] KW_SHO = 24'h53484F;
  localparam logic [23:0] KW_REV = 24'h524556;
  localparam logic [23:0] KW_RES = 24'h524553;

  // event codes
  localparam logic [2:0] EV_NONE  = 3'd0;
  localparam logic [2:0] EV_ERROR = 3'd1;
  localparam logic [2:0] EV_CHA   = 3'd2;
  localparam logic [2:0] EV_ACC   = 3'd3;
  localparam logic [2:0] EV_SHO   = 3'd4;
  localparam logic [2:0] EV_REV   = 3'd5;
  localparam logic [2:0] EV_RES   = 3'd6;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_STRAY = 2'd1;
  localparam logic [1:0] ERR_LONG  = 2'd2;
  localparam logic [1:0] ERR_FRAME = 2'd3;

  // classified character, front to back
  typedef struct packed {
    logic [7:0] data;
    logic       is_dollar;
    logic       is_star;
    logic       is_newline;
    logic       is_comma;
    logic       is_minus;
    logic       is_digit;
    logic       is_hex;
    logic [3:0] nibble;
  } byte_class_t;

  // one result item
  typedef struct packed {
    logic        status;
    logic [2:0]  event_type;
    logic [1:0]  error_code;
    logic [15:0] first_value;
    logic [15:0] second_value;
    logic [15:0] third_value;
  } result_t;

endpackage

@@ rtl/core/nsd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_front
// Input side: takes received characters and classifies them (framing marks,
// separators, decimal and hex digits) before they enter the item queue.
// ----------------------------------------------------------------------------
module nsd_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           rx_byte,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 push_valid,
  output nsd_pkg::byte_class_t push_item,
  input  logic                 push_ready
);
  import nsd_pkg::*;

  logic is_upper_hex;
  logic is_lower_hex;
  logic seen_reset;

  // hold off input during reset, until seen_reset is set after its release
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_reset <= 1'b0;
    end else begin
      seen_reset <= 1'b1;
    end
  end

  // handshake passes straight into the queue
  assign in_ready   = push_ready && seen_reset;
  assign push_valid = in_valid && seen_reset;

  // character classes
  assign is_upper_hex = (rx_byte >= 8'h41) && (rx_byte <= 8'h46);
  assign is_lower_hex = (rx_byte >= 8'h61) && (rx_byte <= 8'h66);

  always_comb begin
    push_item            = '0;
    push_item.data       = rx_byte;
    push_item.is_dollar  = (rx_byte == CH_DOLLAR);
    push_item.is_star    = (rx_byte == CH_STAR);
    push_item.is_newline = (rx_byte == CH_NEWLINE);
    push_item.is_comma   = (rx_byte == CH_COMMA);
    push_item.is_minus   = (rx_byte == CH_MINUS);
    push_item.is_digit   = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
    push_item.is_hex     = push_item.is_digit || is_upper_hex || is_lower_hex;
    // letters a-f and A-F map to 10..15 by low nibble plus nine
    if (is_upper_hex || is_lower_hex) begin
      push_item.nibble = rx_byte[3:0] + 4'd9;
    end else if (push_item.is_digit) begin
      push_item.nibble = rx_byte[3:0];
    end else begin
      push_item.nibble = 4'd0;
    end
  end

endmodule

@@ rtl/core/nsd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_queue
// Two-entry item queue between the classifier and the parser, so that each
// side can stall without holding the other.
// ----------------------------------------------------------------------------
module nsd_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  input  nsd_pkg::byte_class_t push_item,
  output logic                 push_ready,
  output logic                 pop_valid,
  output nsd_pkg::byte_class_t pop_item,
  input  logic                 pop_ready
);
  import nsd_pkg::*;

  byte_class_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QCNT_W-1:0]       count;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/nsd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsd_back
// Sentence parser: frame state machine, checksum, tokenizer, keyword match
// and field conversion, with the result held in an output register.
// ----------------------------------------------------------------------------
module nsd_back #(
  parameter int MAX_PAYLOAD = nsd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  nsd_pkg::byte_class_t q_item,
  output logic                 q_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nsd_pkg::result_t     result
);
  import nsd_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_SUM
  } phase_t;

  typedef enum logic [1:0] {
    FS_START,
    FS_NEG,
    FS_POS,
    FS_STOP
  } fstate_t;

  phase_t         phase, phase_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]     running_xor, running_xor_next;
  logic [2:0]     token_number, token_number_next;
  logic [23:0]    keyword_chars, keyword_chars_next;
  logic [2:0]     keyword_length, keyword_length_next;
  logic           token_open, token_open_next;
  logic [15:0]    field_accum, field_accum_next;
  fstate_t        field_state, field_state_next;
  logic [15:0]    field_values [3];
  logic [15:0]    field_values_next [3];
  logic [7:0]     sum_digits, sum_digits_next;
  logic [1:0]     sum_count, sum_count_next;
  logic           sum_bad, sum_bad_next;
  result_t        result_next;
  logic           advance;

  // take the next item whenever the output register is free or draining
  assign advance = q_valid && (!out_valid || out_ready);
  assign q_ready = !out_valid || out_ready;

  // next-state and result logic
  always_comb begin
    logic [2:0]  tn_eff;
    fstate_t     fs_eff;
    logic [15:0] acc_eff;
    logic [15:0] acc_new;
    logic [1:0]  idx;
    logic [2:0]  kw_event;
    logic [2:0]  kw_fields;

    phase_next          = phase;
    byte_count_next     = byte_count;
    running_xor_next    = running_xor;
    token_number_next   = token_number;
    keyword_chars_next  = keyword_chars;
    keyword_length_next = keyword_length;
    token_open_next     = token_open;
    field_accum_next    = field_accum;
    field_state_next    = field_state;
    field_values_next   = field_values;
    sum_digits_next     = sum_digits;
    sum_count_next      = sum_count;
    sum_bad_next        = sum_bad;
    result_next         = '0;
    tn_eff              = token_number;
    fs_eff              = field_state;
    acc_eff             = field_accum;
    acc_new             = '0;
    idx                 = '0;
    kw_event            = EV_NONE;
    kw_fields           = 3'd0;

    unique case (phase)
      PH_DATA: begin
        if (q_item.is_star) begin
          phase_next     = PH_SUM;
          sum_count_next = 2'd0;
        end else if (byte_count < CNT_W'(MAX_PAYLOAD)) begin
          // ordinary payload byte
          running_xor_next = running_xor ^ q_item.data;
          byte_count_next  = byte_count + 1'b1;
          if (q_item.is_comma) begin
            token_open_next = 1'b0;
          end else begin
            // open a new token
            if (!token_open) begin
              token_open_next = 1'b1;
              if (token_number < 3'd7) begin
                tn_eff = token_number + 3'd1;
              end
              token_number_next = tn_eff;
              fs_eff            = FS_START;
              acc_eff           = 16'd0;
              field_accum_next  = 16'd0;
              field_state_next  = FS_START;
            end
            if (tn_eff == 3'd1) begin
              // keyword token
              if (keyword_length < 3'd3) begin
                keyword_chars_next = {keyword_chars[15:0], q_item.data};
              end
              if (keyword_length < 3'd7) begin
                keyword_length_next = keyword_length + 3'd1;
              end
            end else if (tn_eff >= 3'd2 && tn_eff <= 3'd4) begin
              // numeric field, atoi style
              idx     = 2'(tn_eff - 3'd2);
              acc_new = (acc_eff << 3) + (acc_eff << 1) + {12'd0, q_item.data[3:0]};
              unique case (fs_eff)
                FS_START: begin
                  if (q_item.is_minus) begin
                    field_state_next = FS_NEG;
                  end else if (!q_item.is_digit) begin
                    field_state_next = FS_STOP;
                  end else begin
                    field_state_next       = FS_POS;
                    field_accum_next       = acc_new;
                    field_values_next[idx] = acc_new;
                  end
                end
                FS_NEG: begin
                  if (!q_item.is_digit) begin
                    field_state_next = FS_STOP;
                  end else begin
                    field_accum_next       = acc_new;
                    field_values_next[idx] = 16'd0 - acc_new;
                  end
                end
                FS_POS: begin
                  if (!q_item.is_digit) begin
                    field_state_next = FS_STOP;
                  end else begin
                    field_accum_next       = acc_new;
                    field_values_next[idx] = acc_new;
                  end
                end
                FS_STOP: begin
                  field_state_next = FS_STOP;
                end
              endcase
            end
          end
        end else begin
          phase_next             = PH_IDLE;
          result_next.status     = 1'b1;
          result_next.event_type = EV_ERROR;
          result_next.error_code = ERR_LONG;
        end
      end
      PH_SUM: begin
        if (q_item.is_newline) begin
          phase_next = PH_IDLE;
          // keyword decode
          if (keyword_length == 3'd3) begin
            priority if (keyword_chars == KW_CHA) begin
              kw_event = EV_CHA; kw_fields = 3'd1;
            end else if (keyword_chars == KW_ACC) begin
              kw_event = EV_ACC; kw_fields = 3'd1;
            end else if (keyword_chars == KW_SHO) begin
              kw_event = EV_SHO; kw_fields = 3'd2;
            end else if (keyword_chars == KW_REV) begin
              kw_event = EV_REV; kw_fields = 3'd1;
            end else if (keyword_chars == KW_RES) begin
              kw_event = EV_RES; kw_fields = 3'd3;
            end else begin
              kw_event = EV_NONE; kw_fields = 3'd0;
            end
          end
          if (sum_count != 2'd2 || sum_bad || sum_digits != running_xor ||
              kw_event == EV_NONE || token_number != kw_fields + 3'd1) begin
            result_next.status     = 1'b1;
            result_next.event_type = EV_ERROR;
            result_next.error_code = ERR_FRAME;
          end else begin
            result_next.event_type   = kw_event;
            result_next.first_value  = field_values[0];
            result_next.second_value = field_values[1];
            result_next.third_value  = field_values[2];
          end
        end else if (sum_count < 2'd2) begin
          // checksum digit, a non-hex digit counts as zero and marks bad
          sum_digits_next = {sum_digits[3:0], q_item.is_hex ? q_item.nibble : 4'd0};
          sum_bad_next    = sum_bad || !q_item.is_hex;
          sum_count_next  = sum_count + 2'd1;
        end else begin
          phase_next             = PH_IDLE;
          result_next.status     = 1'b1;
          result_next.event_type = EV_ERROR;
          result_next.error_code = ERR_FRAME;
        end
      end
      default: begin
        if (q_item.is_dollar) begin
          // start of frame clears everything
          phase_next           = PH_DATA;
          byte_count_next      = '0;
          running_xor_next     = 8'd0;
          token_number_next    = 3'd0;
          keyword_chars_next   = 24'd0;
          keyword_length_next  = 3'd0;
          token_open_next      = 1'b0;
          field_accum_next     = 16'd0;
          field_state_next     = FS_START;
          field_values_next[0] = 16'd0;
          field_values_next[1] = 16'd0;
          field_values_next[2] = 16'd0;
          sum_digits_next      = 8'd0;
          sum_count_next       = 2'd0;
          sum_bad_next         = 1'b0;
        end else begin
          phase_next             = PH_IDLE;
          result_next.status     = 1'b1;
          result_next.event_type = EV_ERROR;
          result_next.error_code = ERR_STRAY;
        end
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      byte_count      <= '0;
      running_xor     <= 8'd0;
      token_number    <= 3'd0;
      keyword_chars   <= 24'd0;
      keyword_length  <= 3'd0;
      token_open      <= 1'b0;
      field_accum     <= 16'd0;
      field_state     <= FS_START;
      field_values[0] <= 16'd0;
      field_values[1] <= 16'd0;
      field_values[2] <= 16'd0;
      sum_digits      <= 8'd0;
      sum_count       <= 2'd0;
      sum_bad         <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (advance) begin
        phase          <= phase_next;
        byte_count     <= byte_count_next;
        running_xor    <= running_xor_next;
        token_number   <= token_number_next;
        keyword_chars  <= keyword_chars_next;
        keyword_length <= keyword_length_next;
        token_open     <= token_open_next;
        field_accum    <= field_accum_next;
        field_state    <= field_state_next;
        field_values   <= field_values_next;
        sum_digits     <= sum_digits_next;
        sum_count      <= sum_count_next;
        sum_bad        <= sum_bad_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

@@ rtl/core/nmea_sentence_deframer_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_sentence_deframer_unit
// Byte-serial deframer for '$payload*hh' sentences ended by a newline.
// ----------------------------------------------------------------------------
// Input channel: rx_byte with in_valid / in_ready, one received character
// per item. Output channel: status, event_type, error_code and three field
// values with out_valid / out_ready, exactly one result item per character.
// A character is classified on entry and written to a two-entry queue; the
// parser takes it from the queue and loads the output register. While the
// receiver keeps out_ready high, the block takes one character every cycle.
// The parser updates all frame state for each character it takes; the
// field conversion is one multiply by ten done as shift and add.
// When the receiver stalls, the output register holds its result and the
// queue absorbs up to two more characters before in_ready drops; the parser
// resumes as soon as the result is taken.
// Reset (rst, synchronous) returns the frame state to idle, empties the
// queue and the output register; in_ready stays low during reset and in the
// cycle after it.
// Good sentences report their keyword event and fields; every error gives
// event_type error with the code of the fault and zero field values.
// ----------------------------------------------------------------------------
module nmea_sentence_deframer_unit #(
  parameter int MAX_PAYLOAD = nsd_pkg::MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  rx_byte,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        status,
  output logic [2:0]  event_type,
  output logic [1:0]  error_code,
  output logic [15:0] first_value,
  output logic [15:0] second_value,
  output logic [15:0] third_value,
  output logic        out_valid,
  input  logic        out_ready
);
  import nsd_pkg::*;

  logic        push_valid;
  logic        push_ready;
  byte_class_t push_item;
  logic        pop_valid;
  logic        pop_ready;
  byte_class_t pop_item;
  result_t     result;

  // classifier
  nsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx_byte),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // item queue
  nsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // parser
  nsd_back #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (pop_valid),
    .q_item    (pop_item),
    .q_ready   (pop_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  // result fields
  assign status       = result.status;
  assign event_type   = result.event_type;
  assign error_code   = result.error_code;
  assign first_value  = result.first_value;
  assign second_value = result.second_value;
  assign third_value  = result.third_value;

  // error flag agrees with the event type
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == (event_type == EV_ERROR)))
    else $error("status disagrees with event type");

  // an error code comes with the error flag and only then
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((error_code != ERR_NONE) == status))
    else $error("error code disagrees with status");

  // field values are zero unless a keyword event is reported
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (event_type == EV_NONE || event_type == EV_ERROR)) |->
      (first_value == 16'd0 && second_value == 16'd0 && third_value == 16'd0))
    else $error("field values set without a keyword event");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sentence deframer. Directed sentences cover each
// keyword, field conversion corners, empty tokens, the payload limit and every
// framing and checksum fault. Random sentences, broken frames and line noise
// follow. Both channels idle at random, and the receiver holds off for long
// stretches so that the block fills up. A predictor tracks the framing state
// per accepted character, and every result item is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import nsd_pkg::*;

  localparam int PAYLOAD_LIMIT = MAX_PAYLOAD_DEF;
  localparam int BYTE_TARGET   = 900;
  localparam int QUIET_LIMIT   = 1000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int HOLD_SPACING  = 400;
  localparam int PRINT_LIMIT   = 40;

  // character codes not in the package
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UP_A    = 8'h41;
  localparam logic [7:0] CH_UP_F    = 8'h46;
  localparam logic [7:0] CH_LO_A    = 8'h61;
  localparam logic [7:0] CH_LO_F    = 8'h66;
  localparam logic [7:0] CH_NOT_HEX = 8'h47;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TOP     = 8'hFF;

  typedef enum logic [1:0] {PH_IDLE, PH_BODY, PH_CHECK} frame_phase_t;
  typedef enum logic [1:0] {FLD_START, FLD_NEG, FLD_POS, FLD_STOP} field_mode_t;
  typedef enum int {
    SUM_UPPER, SUM_LOWER, SUM_WRONG, SUM_NOTHEX, SUM_NONE, SUM_SHORT, SUM_EXTRA
  } sum_style_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [7:0]  rx_byte = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        status;
  logic [2:0]  event_type;
  logic [1:0]  error_code;
  logic [15:0] first_value;
  logic [15:0] second_value;
  logic [15:0] third_value;
  logic        out_valid;
  logic        out_ready = 1'b0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nmea_sentence_deframer_unit #(
    .MAX_PAYLOAD(PAYLOAD_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .rx_byte(rx_byte),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status(status),
    .event_type(event_type),
    .error_code(error_code),
    .first_value(first_value),
    .second_value(second_value),
    .third_value(third_value),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  // predictor state
  frame_phase_t frame_phase;
  logic [6:0]   body_len;
  logic [7:0]   body_xor;
  logic [2:0]   token_idx;
  logic [23:0]  kw_text;
  logic [2:0]   kw_len;
  logic         in_token;
  logic [15:0]  num_acc;
  field_mode_t  num_mode;
  logic [15:0]  field_val [3];
  logic [7:0]   sum_value;
  logic [1:0]   sum_len;
  logic         sum_invalid;

  result_t    sentence_results [$];
  logic [7:0] pending_bytes [$];
  logic [7:0] frame_body [$];

  string kw_names [5] = '{"CHA", "ACC", "SHO", "REV", "RES"};
  int    kw_fields [5] = '{1, 1, 2, 1, 3};

  int bytes_total   = 0;
  int results_seen  = 0;
  int mismatch_count = 0;
  int quiet_cycles  = 0;

  // sender and receiver pacing
  int send_wait = 0;
  int send_mode_left = 0;
  bit send_calm = 1'b1;
  int recv_wait = 0;
  int recv_mode_left = 0;
  bit recv_calm = 1'b1;
  int hold_wait = 0;
  int next_hold_at = 300;
  result_t want;

  function automatic result_t make_result(input logic [2:0] ev, input logic [1:0] err,
                                          input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
    result_t r;
    r.status = (ev == EV_ERROR);
    r.event_type = ev;
    r.error_code = err;
    r.first_value = a;
    r.second_value = b;
    r.third_value = c;
    return r;
  endfunction

  task automatic clear_frame();
    body_len = '0;
    body_xor = '0;
    token_idx = '0;
    kw_text = '0;
    kw_len = '0;
    in_token = 1'b0;
    num_acc = '0;
    num_mode = FLD_START;
    field_val[0] = '0;
    field_val[1] = '0;
    field_val[2] = '0;
    sum_value = '0;
    sum_len = '0;
    sum_invalid = 1'b0;
  endtask

  // payload character: checksum, tokenizer, keyword and field conversion
  task automatic take_body_byte(input logic [7:0] b);
    logic       is_digit;
    logic [1:0] slot;
    is_digit = (b >= CH_ZERO && b <= CH_NINE);
    body_xor = body_xor ^ b;
    body_len = body_len + 7'd1;
    if (b == CH_COMMA) begin
      in_token = 1'b0;
    end else begin
      if (!in_token) begin
        in_token = 1'b1;
        if (token_idx < 3'd7) token_idx = token_idx + 3'd1;
        num_acc = '0;
        num_mode = FLD_START;
      end
      if (token_idx == 3'd1) begin
        if (kw_len < 3'd3) kw_text = {kw_text[15:0], b};
        if (kw_len < 3'd7) kw_len = kw_len + 3'd1;
      end else if (token_idx >= 3'd2 && token_idx <= 3'd4) begin
        slot = 2'(token_idx - 3'd2);
        if (num_mode == FLD_START && b == CH_MINUS) begin
          num_mode = FLD_NEG;
        end else if (num_mode == FLD_STOP || !is_digit) begin
          num_mode = FLD_STOP;
        end else begin
          if (num_mode == FLD_START) num_mode = FLD_POS;
          num_acc = num_acc * 16'd10 + {12'd0, b[3:0]};
          field_val[slot] = (num_mode == FLD_NEG) ? 16'd0 - num_acc : num_acc;
        end
      end
    end
  endtask

  // sentence verdict at the newline
  function automatic result_t close_sentence();
    logic [2:0] ev;
    int         need;
    ev = EV_NONE;
    need = 0;
    if (kw_len == 3'd3) begin
      case (kw_text)
        KW_CHA: begin ev = EV_CHA; need = 1; end
        KW_ACC: begin ev = EV_ACC; need = 1; end
        KW_SHO: begin ev = EV_SHO; need = 2; end
        KW_REV: begin ev = EV_REV; need = 1; end
        KW_RES: begin ev = EV_RES; need = 3; end
        default: ;
      endcase
    end
    if (sum_len != 2'd2 || sum_invalid || sum_value != body_xor || ev == EV_NONE ||
        int'(token_idx) != need + 1)
      return make_result(EV_ERROR, ERR_FRAME, 16'd0, 16'd0, 16'd0);
    return make_result(ev, ERR_NONE, field_val[0], field_val[1], field_val[2]);
  endfunction

  // one accepted character gives one expected result item
  task automatic track_byte(input logic [7:0] b);
    result_t    r;
    logic [3:0] nib;
    r = make_result(EV_NONE, ERR_NONE, 16'd0, 16'd0, 16'd0);
    case (frame_phase)
      PH_BODY: begin
        if (b == CH_STAR) begin
          frame_phase = PH_CHECK;
          sum_len = '0;
        end else if (body_len < 7'(PAYLOAD_LIMIT)) begin
          take_body_byte(b);
        end else begin
          frame_phase = PH_IDLE;
          r = make_result(EV_ERROR, ERR_LONG, 16'd0, 16'd0, 16'd0);
        end
      end
      PH_CHECK: begin
        if (b == CH_NEWLINE) begin
          frame_phase = PH_IDLE;
          r = close_sentence();
        end else if (sum_len < 2'd2) begin
          nib = 4'd0;
          if (b >= CH_ZERO && b <= CH_NINE) nib = b[3:0];
          else if ((b >= CH_UP_A && b <= CH_UP_F) || (b >= CH_LO_A && b <= CH_LO_F))
            nib = b[3:0] + 4'd9;
          else sum_invalid = 1'b1;
          sum_value = {sum_value[3:0], nib};
          sum_len = sum_len + 2'd1;
        end else begin
          frame_phase = PH_IDLE;
          r = make_result(EV_ERROR, ERR_FRAME, 16'd0, 16'd0, 16'd0);
        end
      end
      default: begin
        if (b == CH_DOLLAR) begin
          clear_frame();
          frame_phase = PH_BODY;
        end else begin
          frame_phase = PH_IDLE;
          r = make_result(EV_ERROR, ERR_STRAY, 16'd0, 16'd0, 16'd0);
        end
      end
    endcase
    sentence_results.push_back(r);
  endtask

  // stimulus building
  function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
    if (n < 4'd10) return CH_ZERO + {4'd0, n};
    if (lower) return CH_LO_A + {4'd0, n} - 8'd10;
    return CH_UP_A + {4'd0, n} - 8'd10;
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) frame_body.push_back(s[i]);
  endtask

  // wrap the body in framing and a checksum of the given style
  task automatic send_frame(input sum_style_t style);
    logic [7:0] sum_byte;
    sum_byte = '0;
    foreach (frame_body[i]) sum_byte = sum_byte ^ frame_body[i];
    pending_bytes.push_back(CH_DOLLAR);
    foreach (frame_body[i]) pending_bytes.push_back(frame_body[i]);
    pending_bytes.push_back(CH_STAR);
    case (style)
      SUM_LOWER: begin
        pending_bytes.push_back(hex_char(sum_byte[7:4], 1'b1));
        pending_bytes.push_back(hex_char(sum_byte[3:0], 1'b1));
      end
      SUM_WRONG: begin
        sum_byte = sum_byte ^ 8'($urandom_range(1, 255));
        pending_bytes.push_back(hex_char(sum_byte[7:4], 1'b0));
        pending_bytes.push_back(hex_char(sum_byte[3:0], 1'b0));
      end
      SUM_NOTHEX: begin
        if ($urandom_range(0, 1) == 0) begin
          pending_bytes.push_back(CH_NOT_HEX);
          pending_bytes.push_back(hex_char(sum_byte[3:0], 1'b0));
        end else begin
          pending_bytes.push_back(hex_char(sum_byte[7:4], 1'b0));
          pending_bytes.push_back(CH_NOT_HEX);
        end
      end
      SUM_NONE: ;
      SUM_SHORT: pending_bytes.push_back(hex_char(sum_byte[3:0], 1'b0));
      SUM_EXTRA: begin
        pending_bytes.push_back(hex_char(sum_byte[7:4], 1'b0));
        pending_bytes.push_back(hex_char(sum_byte[3:0], 1'b0));
        pending_bytes.push_back(CH_ZERO);
      end
      default: begin
        pending_bytes.push_back(hex_char(sum_byte[7:4], 1'b0));
        pending_bytes.push_back(hex_char(sum_byte[3:0], 1'b0));
      end
    endcase
    pending_bytes.push_back(CH_NEWLINE);
    frame_body.delete();
  endtask

  task automatic send_text(input string s, input sum_style_t style);
    add_text(s);
    send_frame(style);
  endtask

  // mostly well-formed sentences with random content, some noise and broken frames
  task automatic send_random_sentence();
    int         pick;
    int         kw;
    int         count;
    string      txt;
    string      letters;
    sum_style_t style;
    letters = "ACEHORSV";
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 6)) pending_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 13) begin
      repeat ($urandom_range(PAYLOAD_LIMIT + 1, PAYLOAD_LIMIT + 10))
        frame_body.push_back(8'($urandom_range(32, 126)));
      send_frame(SUM_UPPER);
    end else begin
      if ($urandom_range(0, 9) == 0) add_text(",");
      kw = $urandom_range(0, 4);
      case ($urandom_range(0, 11))
        0: add_text($sformatf("%c%c%c", letters[$urandom_range(0, 7)],
                              letters[$urandom_range(0, 7)], letters[$urandom_range(0, 7)]));
        1: add_text(kw_names[kw].substr(0, 1));
        2: add_text({kw_names[kw], "S"});
        default: add_text(kw_names[kw]);
      endcase
      count = kw_fields[kw];
      if ($urandom_range(0, 4) == 0) count = $urandom_range(0, 5);
      repeat (count) begin
        if ($urandom_range(0, 5) == 0) add_text(",,");
        else add_text(",");
        case ($urandom_range(0, 6))
          0: txt = $sformatf("%0d", $urandom_range(0, 9));
          1: txt = $sformatf("%0d", $urandom_range(0, 99999));
          2: txt = $sformatf("-%0d", $urandom_range(0, 70000));
          3: txt = $sformatf("%0d%c%0d", $urandom_range(0, 999),
                             8'($urandom_range(33, 126)), $urandom_range(0, 99));
          4: txt = "-";
          5: txt = $sformatf("%0d", $urandom_range(65530, 65540));
          default: txt = $sformatf("%c%0d", 8'($urandom_range(33, 126)),
                                   $urandom_range(0, 99));
        endcase
        add_text(txt);
        if ($urandom_range(0, 19) == 0) frame_body.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) add_text(",");
      pick = $urandom_range(0, 99);
      if (pick < 40) style = SUM_UPPER;
      else if (pick < 80) style = SUM_LOWER;
      else style = sum_style_t'($urandom_range(int'(SUM_WRONG), int'(SUM_EXTRA)));
      send_frame(style);
    end
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int next_gap(input bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // driver: offers characters from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) track_byte(rx_byte);
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          rx_byte <= pending_bytes.pop_front();
          in_valid <= 1'b1;
          if (send_mode_left == 0) begin
            send_calm = ($urandom_range(0, 2) == 0);
            send_mode_left = $urandom_range(20, 120);
          end
          send_mode_left--;
          send_wait = next_gap(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long hold-off now and then so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_wait <= 0;
    end else if (hold_wait > 0) begin
      hold_wait <= hold_wait - 1;
    end else if (results_seen >= next_hold_at) begin
      hold_wait <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_SPACING;
    end
  end

  // monitor: takes result items and compares them with the predicted ones
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (sentence_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing predicted",
                                    results_seen));
        end else begin
          want = sentence_results.pop_front();
          if (status !== want.status)
            report_mismatch($sformatf("result %0d status %b, expected %b",
                                      results_seen, status, want.status));
          if (event_type !== want.event_type)
            report_mismatch($sformatf("result %0d event_type %0d, expected %0d",
                                      results_seen, event_type, want.event_type));
          if (error_code !== want.error_code)
            report_mismatch($sformatf("result %0d error_code %0d, expected %0d",
                                      results_seen, error_code, want.error_code));
          if (first_value !== want.first_value)
            report_mismatch($sformatf("result %0d first_value %0d, expected %0d",
                                      results_seen, first_value, want.first_value));
          if (second_value !== want.second_value)
            report_mismatch($sformatf("result %0d second_value %0d, expected %0d",
                                      results_seen, second_value, want.second_value));
          if (third_value !== want.third_value)
            report_mismatch($sformatf("result %0d third_value %0d, expected %0d",
                                      results_seen, third_value, want.third_value));
        end
        if (recv_mode_left == 0) begin
          recv_calm = ($urandom_range(0, 2) == 0);
          recv_mode_left = $urandom_range(20, 120);
        end
        recv_mode_left--;
        recv_wait = next_gap(recv_calm);
      end
      if (hold_wait > 0) begin
        out_ready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus, reset and end of run
  initial begin
    frame_phase = PH_IDLE;
    clear_frame();

    // stray bytes at both ends of the byte range
    pending_bytes.push_back(CH_TOP);
    pending_bytes.push_back(CH_NUL);
    // each keyword, both checksum cases, field corners, empty tokens
    send_text("CHA,12", SUM_UPPER);
    send_text("ACC,-7", SUM_LOWER);
    send_text(",SHO,,3,,-65535", SUM_UPPER);
    send_text("REV,70000", SUM_LOWER);
    send_text("RES,1,2x9,-", SUM_UPPER);
    send_text("CHA,$1", SUM_UPPER);
    // NUL inside a field
    add_text("REV,");
    frame_body.push_back(CH_NUL);
    send_frame(SUM_UPPER);
    // payload exactly at the limit, then one byte over
    add_text("CHA,5");
    repeat (PAYLOAD_LIMIT - 5) add_text(",");
    send_frame(SUM_UPPER);
    add_text("CHA,5");
    repeat (PAYLOAD_LIMIT - 4) add_text(",");
    send_frame(SUM_UPPER);
    // checksum faults
    send_text("CHA,1", SUM_WRONG);
    send_text("ACC,2", SUM_NOTHEX);
    send_text("REV,3", SUM_NONE);
    send_text("REV,3", SUM_SHORT);
    send_text("RES,1,2,3", SUM_EXTRA);
    // sentence faults: unknown keyword, field counts, no token, long keyword
    send_text("XYZ,1", SUM_UPPER);
    send_text("CHA,1,2", SUM_UPPER);
    send_text("", SUM_UPPER);
    send_text(",,,", SUM_LOWER);
    send_text("CHAR,1", SUM_UPPER);
    send_text("RES,1,2,3,4,5,6,7,8", SUM_UPPER);

    while (pending_bytes.size() < BYTE_TARGET) send_random_sentence();
    bytes_total = pending_bytes.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    while (results_seen < bytes_total) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sentence_results.size() != 0)
      report_mismatch($sformatf("%0d predicted results never arrived",
                                sentence_results.size()));
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/nsd_pkg.sv
rtl/core/nsd_front.sv
rtl/core/nsd_queue.sv
rtl/core/nsd_back.sv
rtl/core/nmea_sentence_deframer_unit.sv
tb/tb_top.sv
